[rtl/core/brwg_pkg.sv]
// shared types and register codes for the bicubic resize weight generator
`timescale 1ns / 1ps

package brwg_pkg;

    // width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_SIZE            = 2'd0,
        REG_OUT_SIZE           = 2'd1,
        REG_ALIGN_CORNERS      = 2'd2,
        REG_HALF_PIXEL_CENTERS = 2'd3
    } cfg_reg_t;

endpackage

[rtl/core/brwg_div_cell.sv]
// one restoring division cell: develops one quotient bit per beat
`timescale 1ns / 1ps

module brwg_div_cell #(
    parameter int DEN_W = 15,
    parameter int NUM_W = 28,
    parameter int Q_W   = 42
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DEN_W-1:0] den,
    input  logic             vld_in,
    input  logic             neg_in,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [NUM_W-1:0] div_in,
    input  logic [Q_W-1:0]   quo_in,
    output logic             vld_out,
    output logic             neg_out,
    output logic [DEN_W-1:0] rem_out,
    output logic [NUM_W-1:0] div_out,
    output logic [Q_W-1:0]   quo_out
);

    logic             vld_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] div_reg;
    logic [Q_W-1:0]   quo_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // bring down the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_in, div_in[NUM_W-1]};
        diff     = trial - {1'b0, den};
        ge       = (trial >= {1'b0, den});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    // payload handed to the next cell
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_in;
        rem_reg <= rem_next;
        div_reg <= {div_in[NUM_W-2:0], 1'b0};
        quo_reg <= {quo_in[Q_W-2:0], ge};
    end

    assign vld_out = vld_reg;
    assign neg_out = neg_reg;
    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

[rtl/core/brwg_weight_pipe.sv]
// four-stage pipeline for the Keys cubic weights of the fraction
`timescale 1ns / 1ps

module brwg_weight_pipe #(
    parameter int SW = 14,
    parameter int FB = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  logic signed [FB:0]   t_in,
    input  logic [SW-1:0]        src_in,
    output logic                 vld_out,
    output logic [SW-1:0]        src_out,
    output logic signed [FB:0]   t_out,
    output logic signed [FB+1:0] w0_out,
    output logic signed [FB+1:0] w1_out,
    output logic signed [FB+1:0] w2_out,
    output logic signed [FB+1:0] w3_out
);

    localparam int T2W = 2 * FB + 2;
    localparam int T3W = 3 * FB + 3;
    localparam int AW  = 3 * FB + 6;
    localparam int SH  = 2 * FB + 1;
    localparam int RW  = AW - SH;
    localparam int WW  = FB + 2;
    localparam logic signed [AW-1:0] RND  = {{(AW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    localparam logic signed [AW-1:0] TWO3 = {{(AW-3*FB-2){1'b0}}, 1'b1, {(3*FB+1){1'b0}}};

    logic [3:0]               vld_reg;
    logic signed [FB:0]       t_a_reg, t_b_reg, t_c_reg, t_d_reg;
    logic [SW-1:0]            src_a_reg, src_b_reg, src_c_reg, src_d_reg;
    logic signed [T2W-1:0]    t2_a_reg, t2_b_reg;
    logic signed [T3W-1:0]    t3_b_reg;
    logic signed [AW-1:0]     acc_reg [4];
    logic signed [AW-1:0]     acc_next [4];
    logic signed [WW-1:0]     w_reg [4];
    logic signed [WW-1:0]     w_next [4];
    logic signed [AW-1:0]     e3, e2s, e1s;
    logic signed [AW-1:0]     rnd_sum [4];
    logic signed [RW-1:0]     rs [4];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], vld_in};
        end
    end

    // polynomial sums, scaled by 2^(3*FB+1)
    always_comb
    begin
        e3  = AW'(t3_b_reg);
        e2s = AW'(t2_b_reg) <<< FB;
        e1s = AW'(t_b_reg) <<< (2 * FB);
        acc_next[0] = -e3 + (e2s <<< 1) - e1s;
        acc_next[1] = (e3 <<< 1) + e3 - (e2s <<< 2) - e2s + TWO3;
        acc_next[2] = -(e3 <<< 1) - e3 + (e2s <<< 2) + e1s;
        acc_next[3] = e3 - e2s;
    end

    // round to nearest and saturate
    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            rnd_sum[j] = acc_reg[j] + RND;
            rs[j]      = rnd_sum[j][AW-1:SH];
            if ((&rs[j][RW-1:WW-1]) || !(|rs[j][RW-1:WW-1]))
            begin
                w_next[j] = rs[j][WW-1:0];
            end
            else if (rs[j][RW-1])
            begin
                w_next[j] = {1'b1, {(WW-1){1'b0}}};
            end
            else
            begin
                w_next[j] = {1'b0, {(WW-1){1'b1}}};
            end
        end
    end

    // pipeline stages
    always_ff @(posedge clk)
    begin
        t_a_reg   <= t_in;
        src_a_reg <= src_in;
        t2_a_reg  <= T2W'(t_in) * T2W'(t_in);

        t_b_reg   <= t_a_reg;
        src_b_reg <= src_a_reg;
        t2_b_reg  <= t2_a_reg;
        t3_b_reg  <= T3W'(t2_a_reg) * T3W'(t_a_reg);

        t_c_reg   <= t_b_reg;
        src_c_reg <= src_b_reg;
        for (int j = 0; j < 4; j++)
        begin
            acc_reg[j] <= acc_next[j];
        end

        t_d_reg   <= t_c_reg;
        src_d_reg <= src_c_reg;
        for (int j = 0; j < 4; j++)
        begin
            w_reg[j] <= w_next[j];
        end
    end

    assign vld_out = vld_reg[3];
    assign src_out = src_d_reg;
    assign t_out   = t_d_reg;
    assign w0_out  = w_reg[0];
    assign w1_out  = w_reg[1];
    assign w2_out  = w_reg[2];
    assign w3_out  = w_reg[3];

endmodule

[rtl/core/bicubic_resize_weight_generator_unit.sv]
// top level: source position divider chain and bicubic weight pipeline
`timescale 1ns / 1ps

// channel   direction  beat marked by          payload
// command   in         start && !busy          out_index
// result    out        done (one cycle)        src_index, frac_pos, weight_tap0..3
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// one index is taken every cycle; busy stays low.
// the position numerator is formed in the product register and then the sign/magnitude
// register, then one division cell per quotient bit (2*SIZE_BITS+2 integer
// bits plus FRAC_BITS fraction bits), then the weight pipeline.
// reset clears the registers to in_size 1, out_size 1 and empties the pipeline.
// the result side has no stall; each result stands for one cycle only.

module bicubic_resize_weight_generator_unit #(
    parameter int SIZE_BITS = 13,
    parameter int FRAC_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [SIZE_BITS-1:0]            out_index,
    output logic                            done,
    output logic signed [SIZE_BITS:0]       src_index,
    output logic signed [FRAC_BITS:0]       frac_pos,
    output logic signed [FRAC_BITS+1:0]     weight_tap0,
    output logic signed [FRAC_BITS+1:0]     weight_tap1,
    output logic signed [FRAC_BITS+1:0]     weight_tap2,
    output logic signed [FRAC_BITS+1:0]     weight_tap3,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [brwg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_BITS:0]              cfg_data
);

    localparam int CW    = SIZE_BITS + 1;
    localparam int NUM_W = 2 * SIZE_BITS + 2;
    localparam int DEN_W = SIZE_BITS + 2;
    localparam int Q_W   = NUM_W + FRAC_BITS;

    // configuration registers
    logic [CW-1:0] in_size_reg;
    logic [CW-1:0] out_size_reg;
    logic          align_corners_reg;
    logic          half_pixel_centers_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_size_reg            <= CW'(1);
            out_size_reg           <= CW'(1);
            align_corners_reg      <= 1'b0;
            half_pixel_centers_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (brwg_pkg::cfg_reg_t'(cfg_index))
                brwg_pkg::REG_IN_SIZE:            in_size_reg <= cfg_data;
                brwg_pkg::REG_OUT_SIZE:           out_size_reg <= cfg_data;
                brwg_pkg::REG_ALIGN_CORNERS:      align_corners_reg <= cfg_data[0];
                brwg_pkg::REG_HALF_PIXEL_CENTERS: half_pixel_centers_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // effective ratio terms
    logic [CW-1:0]    nin, nout, n_eff_next, d_eff_next;
    logic [CW-1:0]    hd_reg;
    logic [DEN_W-1:0] den_reg;

    always_comb
    begin
        nin  = (in_size_reg == '0) ? CW'(1) : in_size_reg;
        nout = (out_size_reg == '0) ? CW'(1) : out_size_reg;
        if (align_corners_reg && (nout != CW'(1)))
        begin
            n_eff_next = nin - CW'(1);
            d_eff_next = nout - CW'(1);
        end
        else
        begin
            n_eff_next = nin;
            d_eff_next = nout;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= {d_eff_next, 1'b0};
        hd_reg    <= half_pixel_centers_reg ? d_eff_next : '0;
    end

    // front stages: numerator (2i+hc)*n - hc*d, then sign and magnitude
    logic             v0_reg, v1_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [NUM_W-1:0] mag_reg;
    logic             neg_reg;
    logic signed [NUM_W:0] num;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
        end
    end

    assign num = $signed({1'b0, prod_reg}) - $signed({{(NUM_W+1-CW){1'b0}}, hd_reg});

    always_ff @(posedge clk)
    begin
        prod_reg <= NUM_W'({out_index, half_pixel_centers_reg}) * NUM_W'(n_eff_next);
        neg_reg  <= num[NUM_W];
        mag_reg  <= num[NUM_W] ? NUM_W'(-num) : num[NUM_W-1:0];
    end

    // division chain, one quotient bit per cell
    logic             c_vld [Q_W+1];
    logic             c_neg [Q_W+1];
    logic [DEN_W-1:0] c_rem [Q_W+1];
    logic [NUM_W-1:0] c_div [Q_W+1];
    logic [Q_W-1:0]   c_quo [Q_W+1];

    assign c_vld[0] = v1_reg;
    assign c_neg[0] = neg_reg;
    assign c_rem[0] = '0;
    assign c_div[0] = mag_reg;
    assign c_quo[0] = '0;

    for (genvar g = 0; g < Q_W; g++)
    begin : g_cell
        brwg_div_cell #(
            .DEN_W (DEN_W),
            .NUM_W (NUM_W),
            .Q_W   (Q_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .den     (den_reg),
            .vld_in  (c_vld[g]),
            .neg_in  (c_neg[g]),
            .rem_in  (c_rem[g]),
            .div_in  (c_div[g]),
            .quo_in  (c_quo[g]),
            .vld_out (c_vld[g+1]),
            .neg_out (c_neg[g+1]),
            .rem_out (c_rem[g+1]),
            .div_out (c_div[g+1]),
            .quo_out (c_quo[g+1])
        );
    end

    // apply sign: tap index k-1 and signed fraction
    logic [CW-1:0]          q_low;
    logic [FRAC_BITS-1:0]   tq;
    logic [CW-1:0]          src_val;
    logic signed [FRAC_BITS:0] t_val;

    always_comb
    begin
        q_low   = c_quo[Q_W][FRAC_BITS +: CW];
        tq      = c_quo[Q_W][FRAC_BITS-1:0];
        src_val = c_neg[Q_W] ? ~q_low : q_low - CW'(1);
        t_val   = c_neg[Q_W] ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
    end

    // weight pipeline
    logic [CW-1:0] src_w;

    brwg_weight_pipe #(
        .SW (CW),
        .FB (FRAC_BITS)
    ) u_weights (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (c_vld[Q_W]),
        .t_in    (t_val),
        .src_in  (src_val),
        .vld_out (done),
        .src_out (src_w),
        .t_out   (frac_pos),
        .w0_out  (weight_tap0),
        .w1_out  (weight_tap1),
        .w2_out  (weight_tap2),
        .w3_out  (weight_tap3)
    );

    assign src_index = $signed(src_w);

endmodule
